### hw/rtl/ecdc_pkg.sv
// Shared types and constants for the elevator car and door controller
package ecdc_pkg;

  typedef enum logic [2:0] {
    CAR_GROUND  = 3'd0,
    CAR_CONFIG  = 3'd1,
    CAR_DOWN    = 3'd2,
    CAR_UP      = 3'd3,
    CAR_STOPPED = 3'd4,
    CAR_RETURN  = 3'd5
  } car_mode_t;

  typedef enum logic [2:0] {
    DOOR_CLOSED  = 3'd0,
    DOOR_OPENING = 3'd1,
    DOOR_OPEN    = 3'd2,
    DOOR_TRYING  = 3'd3,
    DOOR_ALARM   = 3'd4,
    DOOR_CLOSING = 3'd5
  } door_mode_t;

  // Sequencer states
  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_ENQ,
    SEQ_CAR,
    SEQ_DOOR,
    SEQ_CMP,
    SEQ_SHIFT,
    SEQ_OUT
  } seq_state_t;

  typedef enum logic [1:0] {
    REG_FLOOR_TRAVEL = 2'd0,
    REG_DOOR_TRAVEL  = 2'd1,
    REG_TOP_FLOOR    = 2'd2,
    REG_BASEMENTS    = 2'd3
  } reg_index_t;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 5;

  // Command from sequencer to datapath
  typedef struct packed {
    logic enq;
    logic car;
    logic door;
    logic cmp;
    logic shift;
  } dp_cmd_t;

  // Status from datapath to sequencer
  typedef struct packed {
    logic shift_busy;
  } dp_status_t;

endpackage

### hw/rtl/ecdc_if.sv
// Valid/ready channel interface
interface ecdc_if #(parameter int W = 1);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/ecdc_ctrl.sv
// Sequencer that steps one tick item through the datapath phases
module ecdc_ctrl
  import ecdc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  seq_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SEQ_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      SEQ_IDLE:  if (in_valid) state_next = SEQ_ENQ;
      SEQ_ENQ:   state_next = SEQ_CAR;
      SEQ_CAR:   state_next = SEQ_DOOR;
      SEQ_DOOR:  state_next = SEQ_CMP;
      SEQ_CMP:   state_next = SEQ_SHIFT;
      SEQ_SHIFT: if (!status.shift_busy) state_next = SEQ_OUT;
      SEQ_OUT:   if (out_ready) state_next = SEQ_IDLE;
      default:   state_next = SEQ_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state)
      SEQ_IDLE:  in_ready = 1'b1;
      SEQ_ENQ:   cmd.enq = 1'b1;
      SEQ_CAR:   cmd.car = 1'b1;
      SEQ_DOOR:  cmd.door = 1'b1;
      SEQ_CMP:   cmd.cmp = 1'b1;
      SEQ_SHIFT: cmd.shift = 1'b1;
      SEQ_OUT:   out_valid = 1'b1;
      default:   ;
    endcase
  end

endmodule

### hw/rtl/ecdc_dp.sv
// Datapath: config registers, queue, car and door state, timers, lamps
module ecdc_dp
  import ecdc_pkg::*;
#(
  parameter int QUEUE_DEPTH      = 10,
  parameter int TICKS_PER_SECOND = 10
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_take,
  input  logic                   request_valid,
  input  logic signed [5:0]      request_floor,
  input  logic                   obstruction,
  input  dp_cmd_t                cmd,
  output dp_status_t             status,
  output logic [2:0]             car_mode_out,
  output logic [2:0]             door_mode_out,
  output logic signed [5:0]      current_floor,
  output logic [1:0]             direction_mark,
  output logic                   moving_lamp,
  output logic                   stopped_lamp,
  output logic                   opening_lamp,
  output logic                   open_lamp,
  output logic                   closing_lamp,
  output logic                   alarm_lamp,
  output logic [3:0]             pending_total
);

  localparam int QA = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QC = $clog2(QUEUE_DEPTH + 1);
  // Timer widths: travel thresholds up to 10 s, hold 2 s, idle 3 s
  localparam int TMAX = 10 * TICKS_PER_SECOND + 2;
  localparam int TW   = $clog2(TMAX + 1);
  localparam int IDLE_LIM = 3 * TICKS_PER_SECOND;
  localparam int IW   = $clog2(IDLE_LIM + 1);
  localparam int HOLD_LIM = 2 * TICKS_PER_SECOND;
  localparam int BLINK_LIM = TICKS_PER_SECOND / 2;
  localparam int BW   = $clog2(BLINK_LIM + 2);
  localparam int SW   = 4;

  logic [3:0] floor_sec, door_sec;
  logic [4:0] top_floor;
  logic [2:0] basements;

  car_mode_t  car_mode;
  door_mode_t door_mode;
  logic signed [5:0] pos;
  logic signed [5:0] queue [QUEUE_DEPTH];
  logic [QC-1:0] count;
  logic [QA-1:0] shift_idx;
  logic          shifting;
  logic [TW-1:0] tt_up, tt_dn, tt_ret, dt_open, dt_hold, dt_close;
  logic [IW-1:0] idle;
  logic [BW-1:0] blink;
  // control flags
  logic cf_up, cf_down, cf_openseq, cf_closeseq, cf_atfloor, cf_moveen;
  // entry flags
  logic ef_ground, ef_stop, ef_opening, ef_opened, ef_closing;
  logic lb_moving, lb_stopped, lb_opening, lb_open, lb_closing, lb_alarm;
  logic [1:0] dir;
  logic req_v, obst;
  logic signed [5:0] req_f;

  // Thresholds in ticks; one small multiply each
  logic [TW-1:0] car_thr, door_thr;
  assign car_thr  = TW'(floor_sec * TICKS_PER_SECOND);
  assign door_thr = TW'(door_sec * TICKS_PER_SECOND);

  logic signed [5:0] head;
  assign head = queue[0];
  assign status.shift_busy = shifting;

  logic signed [6:0] lo_lim, hi_lim;
  assign lo_lim = -$signed({4'd0, basements});
  assign hi_lim = $signed({2'd0, top_floor});

  always_ff @(posedge clk) begin
    if (in_take) begin
      req_v <= request_valid;
      req_f <= request_floor;
      obst  <= obstruction;
    end
  end

  // Configuration writes, out of range values ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      floor_sec <= 4'd1;
      door_sec  <= 4'd1;
      top_floor <= 5'd16;
      basements <= 3'd3;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_FLOOR_TRAVEL:
          if (cfg_data >= 5'd1 && cfg_data <= 5'd10) floor_sec <= cfg_data[3:0];
        REG_DOOR_TRAVEL:
          if (cfg_data >= 5'd1 && cfg_data <= 5'd10) door_sec <= cfg_data[3:0];
        REG_TOP_FLOOR:
          if (cfg_data >= 5'd1 && cfg_data <= 5'd20) top_floor <= cfg_data;
        REG_BASEMENTS:
          if (cfg_data >= 5'd1 && cfg_data <= 5'd5) basements <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      car_mode <= CAR_GROUND;
      door_mode <= DOOR_CLOSED;
      pos <= '0;
      for (int i = 0; i < QUEUE_DEPTH; i++) queue[i] <= '0;
      count <= '0;
      shifting <= 1'b0;
      shift_idx <= '0;
      tt_up <= '0; tt_dn <= '0; tt_ret <= '0;
      dt_open <= '0; dt_hold <= '0; dt_close <= '0;
      idle <= '0;
      blink <= '0;
      {cf_up, cf_down, cf_openseq, cf_closeseq, cf_atfloor, cf_moveen} <= '0;
      {ef_ground, ef_stop, ef_opening, ef_opened, ef_closing} <= '1;
      {lb_moving, lb_stopped, lb_opening, lb_open, lb_closing, lb_alarm} <= 6'b010000;
      dir <= 2'd0;
    end else begin
      // Enqueue a request in range when there is room
      if (cmd.enq) begin
        if (req_v && $signed({req_f[5], req_f}) >= lo_lim &&
            $signed({req_f[5], req_f}) <= hi_lim && count < QC'(QUEUE_DEPTH)) begin
          queue[QA'(count)] <= req_f;
          count <= count + 1'b1;
        end
      end

      // Car state machine
      if (cmd.car) begin
        case (car_mode)
          CAR_GROUND: begin
            logic cu, cs;
            cu = cf_closeseq;
            cs = 1'b0;
            if (ef_ground) begin
              cf_openseq <= 1'b1;
              ef_ground <= 1'b0;
            end
            if (cf_up) begin
              if (!cu) begin
                cf_closeseq <= 1'b1; cs = 1'b1;
              end else if (door_mode == DOOR_CLOSED) begin
                car_mode <= CAR_UP; lb_stopped <= 1'b0; lb_moving <= 1'b1;
                dir <= 2'd1; cf_closeseq <= 1'b0; cs = 1'b1;
              end
            end
            if (cf_down && !cs) begin
              if (!cu) begin
                cf_closeseq <= 1'b1;
              end else if (door_mode == DOOR_CLOSED) begin
                car_mode <= CAR_DOWN; lb_stopped <= 1'b0; lb_moving <= 1'b1;
                dir <= 2'd2; cf_closeseq <= 1'b0;
              end
            end
          end
          CAR_UP, CAR_DOWN: begin
            logic up;
            logic [TW-1:0] t;
            up = (car_mode == CAR_UP);
            t = up ? tt_up : tt_dn;
            if (cf_atfloor) begin
              car_mode <= CAR_STOPPED; lb_stopped <= 1'b1; lb_moving <= 1'b0;
              dir <= 2'd0; cf_moveen <= 1'b0;
              if (up) tt_up <= '0; else tt_dn <= '0;
            end else begin
              if (t >= car_thr) begin
                pos <= up ? pos + 6'sd1 : pos - 6'sd1;
                t = '0;
              end
              if (up) tt_up <= t + 1'b1; else tt_dn <= t + 1'b1;
            end
          end
          CAR_STOPPED: begin
            logic me, up2, dn2;
            logic [IW-1:0] id;
            car_mode_t m;
            me = cf_moveen;
            id = idle;
            m = CAR_STOPPED;
            if (ef_stop) begin
              cf_openseq <= 1'b1; id = '0; ef_stop <= 1'b0; me = 1'b0;
              cf_moveen <= 1'b0;
            end
            up2 = 1'b0; dn2 = 1'b0;
            if (door_mode == DOOR_OPEN) begin
              cf_closeseq <= 1'b1;
            end else if (door_mode == DOOR_CLOSED && me) begin
              up2 = cf_up; dn2 = cf_down;
              if (cf_up || cf_down) begin
                lb_stopped <= 1'b0; lb_moving <= 1'b1;
                cf_atfloor <= 1'b0; cf_closeseq <= 1'b0; ef_stop <= 1'b1;
              end
              if (dn2) begin
                m = CAR_DOWN; dir <= 2'd2;
              end else if (up2) begin
                m = CAR_UP; dir <= 2'd1;
              end
            end
            if (!cf_up && !cf_down && id < IW'(IDLE_LIM)) id = id + 1'b1;
            idle <= id;
            if (id >= IW'(IDLE_LIM) && door_mode == DOOR_CLOSED) begin
              m = CAR_RETURN;
              lb_stopped <= 1'b0; lb_moving <= 1'b1;
              cf_atfloor <= 1'b0; cf_moveen <= 1'b1; ef_stop <= 1'b1;
            end
            car_mode <= m;
          end
          CAR_RETURN: begin
            logic [TW-1:0] t;
            t = tt_ret;
            if (cf_atfloor) begin
              car_mode <= CAR_GROUND; lb_stopped <= 1'b1; lb_moving <= 1'b0;
              dir <= 2'd0; tt_ret <= '0; ef_ground <= 1'b1;
            end else begin
              if (t > car_thr) begin
                if (pos < 0) begin
                  dir <= 2'd1; pos <= pos + 6'sd1;
                end else begin
                  dir <= 2'd2; pos <= pos - 6'sd1;
                end
                t = '0;
              end
              tt_ret <= t + 1'b1;
            end
          end
          default: ;
        endcase
      end

      // Door state machine
      if (cmd.door) begin
        case (door_mode)
          DOOR_CLOSED:
            if (cf_openseq) begin
              door_mode <= DOOR_OPENING; lb_opening <= 1'b1; cf_openseq <= 1'b0;
            end
          DOOR_OPENING: begin
            logic [TW-1:0] t;
            t = ef_opening ? '0 : dt_open;
            if (t < door_thr) t = t + 1'b1;
            ef_opening <= 1'b0;
            if (t >= door_thr) begin
              door_mode <= DOOR_OPEN; cf_moveen <= 1'b0; ef_opening <= 1'b1;
              lb_opening <= 1'b0; lb_open <= 1'b1;
            end
            dt_open <= t;
          end
          DOOR_OPEN: begin
            logic [TW-1:0] t;
            t = ef_opened ? '0 : dt_hold;
            if (t < TW'(HOLD_LIM)) t = t + 1'b1;
            ef_opened <= 1'b0;
            if (t >= TW'(HOLD_LIM) && cf_closeseq) begin
              door_mode <= DOOR_TRYING; ef_opened <= 1'b1;
            end
            dt_hold <= t;
          end
          DOOR_TRYING: begin
            lb_open <= 1'b0;
            if (obst) begin
              door_mode <= DOOR_ALARM;
            end else begin
              door_mode <= DOOR_CLOSING; lb_closing <= 1'b1;
            end
          end
          DOOR_ALARM: begin
            logic [BW-1:0] b;
            logic a;
            b = blink;
            a = lb_alarm;
            if (b < BW'(BLINK_LIM)) b = b + 1'b1;
            if (b >= BW'(BLINK_LIM)) begin
              a = !a; b = '0;
            end
            if (!obst) begin
              door_mode <= DOOR_CLOSING; a = 1'b0;
            end
            blink <= b;
            lb_alarm <= a;
          end
          DOOR_CLOSING: begin
            logic [TW-1:0] t;
            t = ef_closing ? '0 : dt_close;
            if (t < door_thr) t = t + 1'b1;
            ef_closing <= 1'b0;
            if (t >= door_thr && cf_closeseq) begin
              door_mode <= DOOR_CLOSED; cf_closeseq <= 1'b0; ef_closing <= 1'b1;
              lb_closing <= 1'b0;
            end
            dt_close <= t;
          end
          default: ;
        endcase
      end

      // Compare position with queue head; start dequeue shift on arrival
      if (cmd.cmp) begin
        logic u, d;
        u = cf_up; d = cf_down;
        if (count != '0) begin
          if (pos == head) begin
            u = 1'b0; d = 1'b0;
            cf_atfloor <= 1'b1; cf_moveen <= 1'b0;
            shifting <= 1'b1; shift_idx <= '0;
          end else if (pos < head) begin
            u = 1'b1; d = 1'b0; cf_moveen <= 1'b1; cf_atfloor <= 1'b0;
          end else begin
            u = 1'b0; d = 1'b1; cf_moveen <= 1'b1; cf_atfloor <= 1'b0;
          end
        end
        cf_up <= u; cf_down <= d;
        if (car_mode == CAR_RETURN) begin
          if (pos == 6'sd0) begin
            cf_atfloor <= 1'b1; cf_up <= 1'b0; cf_down <= 1'b0; cf_moveen <= 1'b0;
          end else begin
            if (u || d) lb_stopped <= 1'b1;
            if (d) car_mode <= CAR_DOWN;
            else if (u) car_mode <= CAR_UP;
          end
        end
      end

      // Dequeue: one entry moves forward per cycle
      if (cmd.shift && shifting) begin
        if (QC'(shift_idx) + 1'b1 < count) begin
          queue[shift_idx] <= queue[QA'(QC'(shift_idx) + 1'b1)];
          shift_idx <= shift_idx + 1'b1;
        end else begin
          queue[shift_idx] <= '0;
          count <= count - 1'b1;
          shifting <= 1'b0;
        end
      end
    end
  end

  assign car_mode_out   = car_mode;
  assign door_mode_out  = door_mode;
  assign current_floor  = pos;
  assign direction_mark = dir;
  assign moving_lamp    = lb_moving;
  assign stopped_lamp   = lb_stopped;
  assign opening_lamp   = lb_opening;
  assign open_lamp      = lb_open;
  assign closing_lamp   = lb_closing;
  assign alarm_lamp     = lb_alarm;
  assign pending_total  = SW'(count);

endmodule

### hw/rtl/elevator_car_and_door_controller_top.sv
// Top level of the elevator car and door controller
//
// One input item is one 100 ms tick: request_valid, request_floor and
// obstruction on channel req. Every accepted item yields one result item on
// channel res with car and door modes, floor, direction, lamps and queue size.
// A sequencer walks each item through enqueue, car step, door step, head
// compare and queue shift; the shift moves one queue entry per cycle.
// After accept, an item passes the enqueue, car, door, compare and shift
// states before the result is shown; the shift state holds while the queue
// shifts, once the car reaches the queue head. One item is in work at a
// time; the next is accepted in the cycle after the result is taken.
// While the receiver stalls, the result holds and no new item is accepted.
// Synchronous reset rst puts the car at floor 0 on the ground, doors closed,
// queue empty, registers at their defaults. Configuration is written through
// cfg_we/cfg_index/cfg_data; out of range values are ignored.
module elevator_car_and_door_controller_top
  import ecdc_pkg::*;
#(
  parameter int QUEUE_DEPTH      = 10,
  parameter int TICKS_PER_SECOND = 10
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  ecdc_if.sink                   req,
  ecdc_if.source                 res
);

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       in_ready;
  logic       out_valid;

  logic [2:0] car_mode_out, door_mode_out;
  logic signed [5:0] current_floor;
  logic [1:0] direction_mark;
  logic moving_lamp, stopped_lamp, opening_lamp, open_lamp, closing_lamp, alarm_lamp;
  logic [3:0] pending_total;

  ecdc_ctrl u_ctrl (
    .clk, .rst,
    .in_valid (req.valid),
    .in_ready,
    .out_valid,
    .out_ready (res.ready),
    .status,
    .cmd
  );

  ecdc_dp #(
    .QUEUE_DEPTH      (QUEUE_DEPTH),
    .TICKS_PER_SECOND (TICKS_PER_SECOND)
  ) u_dp (
    .clk, .rst,
    .cfg_we, .cfg_index, .cfg_data,
    .in_take       (req.valid & in_ready),
    .request_valid (req.data[0]),
    .request_floor (req.data[6:1]),
    .obstruction   (req.data[7]),
    .cmd, .status,
    .car_mode_out, .door_mode_out, .current_floor, .direction_mark,
    .moving_lamp, .stopped_lamp, .opening_lamp, .open_lamp, .closing_lamp,
    .alarm_lamp, .pending_total
  );

  assign req.ready = in_ready;
  assign res.valid = out_valid;
  assign res.data  = {pending_total, alarm_lamp, closing_lamp, open_lamp, opening_lamp,
                      stopped_lamp, moving_lamp, direction_mark, current_floor,
                      door_mode_out, car_mode_out};

  // No new item while a result is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> !req.ready) else $error("accept during result");
  // Result stays until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.ready |=> res.valid && $stable(res.data))
    else $error("result dropped");
  // Queue count never exceeds its depth
  a_count: assert property (@(posedge clk) disable iff (rst)
    pending_total <= 4'(QUEUE_DEPTH)) else $error("queue overflow");

endmodule

### bench/elevator_car_and_door_controller_top_tb.sv
// Self-checking testbench for the elevator car and door controller top level
module elevator_car_and_door_controller_top_tb
  import ecdc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TICKS_PER_SECOND = 10;
  localparam int QUEUE_DEPTH      = 10;
  localparam int CYCLE_LIMIT      = 600000;
  localparam int HOLD_CYCLES      = 300;
  localparam int PHASE_ITEMS      = 500;
  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_UP   = 2'd1;
  localparam logic [1:0] DIR_DOWN = 2'd2;

  // bit 0 request valid, bits 6:1 floor, bit 7 obstruction
  typedef struct packed {
    logic              obs;
    logic signed [5:0] flr;
    logic              rq;
  } tick_t;

  // car mode in the low bits, pending count in the high bits
  typedef struct packed {
    logic [3:0]        pend;
    logic              al, cl, opn, op, st, mv;
    logic [1:0]        dir;
    logic signed [5:0] flr;
    door_mode_t        door;
    car_mode_t         car;
  } status_t;

  typedef struct {
    bit      rq;
    int      flr;
    bit      obs;
    bit      typed;
    status_t want;
  } row_t;

  localparam status_t DOORS_OPENING_AT_GROUND = '{car: CAR_GROUND, door: DOOR_OPENING,
                                                  flr: 6'sd0, dir: DIR_NONE,
                                                  mv: 1'b0, st: 1'b1, op: 1'b1, opn: 1'b0,
                                                  cl: 1'b0, al: 1'b0, pend: 4'd0};

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  ecdc_if #(.W(8))  req_ch ();
  ecdc_if #(.W(24)) res_ch ();

  elevator_car_and_door_controller_top u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req(req_ch), .res(res_ch)
  );

  always #10 clk = ~clk;

  // shared bench state
  status_t expected_status[$];
  int      errors = 0;
  int      cycles = 0;
  int      idle_mode = 0;
  bit      hold_request = 1'b0;
  int      hold_left = 0;

  // predictor state
  int unsigned p_floor_s, p_door_s, p_top, p_bas;
  car_mode_t  p_car;
  door_mode_t p_door;
  int p_pos, p_qn, p_idle, p_blink;
  int p_queue[QUEUE_DEPTH];
  int p_trav[3];
  int p_dtk[3];
  bit f_up, f_dn, f_open, f_close, f_at, f_move;
  bit e_gnd, e_stop, e_opening, e_opened, e_closing;
  bit l_mv, l_st, l_op, l_open, l_cl, l_al;
  logic [1:0] p_dir;

  function automatic int wrap6(int v);
    return int'($signed(v[5:0]));
  endfunction

  function automatic void model_reset();
    p_floor_s = 1; p_door_s = 1; p_top = 16; p_bas = 3;
    p_car = CAR_GROUND; p_door = DOOR_CLOSED;
    p_pos = 0; p_qn = 0; p_idle = 0; p_blink = 0;
    foreach (p_queue[i]) p_queue[i] = 0;
    for (int i = 0; i < 3; i++) begin
      p_trav[i] = 0; p_dtk[i] = 0;
    end
    {f_up, f_dn, f_open, f_close, f_at, f_move} = '0;
    {e_gnd, e_stop, e_opening, e_opened, e_closing} = '1;
    {l_mv, l_op, l_open, l_cl, l_al} = '0;
    l_st = 1'b1;
    p_dir = DIR_NONE;
  endfunction

  function automatic void model_config(reg_index_t idx, int v);
    case (idx)
      REG_FLOOR_TRAVEL: if (v >= 1 && v <= 10) p_floor_s = v;
      REG_DOOR_TRAVEL:  if (v >= 1 && v <= 10) p_door_s = v;
      REG_TOP_FLOOR:    if (v >= 1 && v <= 20) p_top = v;
      REG_BASEMENTS:    if (v >= 1 && v <= 5) p_bas = v;
      default: ;
    endcase
  endfunction

  function automatic void begin_travel(car_mode_t m, logic [1:0] d);
    p_car = m; l_st = 0; l_mv = 1; p_dir = d;
  endfunction

  // car FSM step
  function automatic void car_step();
    int thr;
    int k;
    bit done;
    thr = p_floor_s * TICKS_PER_SECOND;
    done = 0;
    case (p_car)
      CAR_GROUND: begin
        if (e_gnd) begin
          f_open = 1; e_gnd = 0;
        end
        if (f_up) begin
          if (!f_close) begin
            f_close = 1; done = 1;
          end else if (p_door == DOOR_CLOSED) begin
            begin_travel(CAR_UP, DIR_UP); f_close = 0; done = 1;
          end
        end
        if (!done && f_dn) begin
          if (!f_close) f_close = 1;
          else if (p_door == DOOR_CLOSED) begin
            begin_travel(CAR_DOWN, DIR_DOWN); f_close = 0;
          end
        end
      end
      CAR_UP, CAR_DOWN: begin
        k = (p_car == CAR_UP) ? 0 : 1;
        if (f_at) begin
          p_car = CAR_STOPPED; l_st = 1; l_mv = 0; p_dir = DIR_NONE;
          p_trav[k] = 0; f_move = 0;
        end else begin
          if (p_trav[k] >= thr) begin
            p_pos = wrap6(p_pos + ((k == 0) ? 1 : -1));
            p_trav[k] = 0;
          end
          p_trav[k]++;
        end
      end
      CAR_STOPPED: begin
        if (e_stop) begin
          f_open = 1; p_idle = 0; e_stop = 0; f_move = 0;
        end
        if (p_door == DOOR_OPEN) f_close = 1;
        else if (p_door == DOOR_CLOSED && f_move) begin
          if (f_up) begin
            begin_travel(CAR_UP, DIR_UP); f_at = 0; f_close = 0; e_stop = 1;
          end
          if (f_dn) begin
            begin_travel(CAR_DOWN, DIR_DOWN); f_at = 0; f_close = 0; e_stop = 1;
          end
        end
        if (!f_up && !f_dn && p_idle < 3 * TICKS_PER_SECOND) p_idle++;
        if (p_idle >= 3 * TICKS_PER_SECOND && p_door == DOOR_CLOSED && p_car != CAR_GROUND) begin
          p_car = CAR_RETURN; l_st = 0; l_mv = 1; f_at = 0; f_move = 1; e_stop = 1;
        end
      end
      CAR_RETURN: begin
        if (f_at) begin
          p_car = CAR_GROUND; l_st = 1; l_mv = 0; p_dir = DIR_NONE;
          p_trav[2] = 0; e_gnd = 1;
        end else begin
          if (p_trav[2] > thr) begin
            if (p_pos < 0) begin
              p_dir = DIR_UP; p_pos = wrap6(p_pos + 1);
            end else begin
              p_dir = DIR_DOWN; p_pos = wrap6(p_pos - 1);
            end
            p_trav[2] = 0;
          end
          p_trav[2]++;
        end
      end
      default: ;
    endcase
  endfunction

  // door FSM step
  function automatic void door_step(bit blocked);
    int thr;
    thr = p_door_s * TICKS_PER_SECOND;
    case (p_door)
      DOOR_CLOSED: if (f_open) begin
        p_door = DOOR_OPENING; l_op = 1; f_open = 0;
      end
      DOOR_OPENING: begin
        if (e_opening) begin
          p_dtk[0] = 0; e_opening = 0;
        end
        if (p_dtk[0] < thr) p_dtk[0]++;
        if (p_dtk[0] >= thr) begin
          p_door = DOOR_OPEN; f_move = 0; e_opening = 1; l_op = 0; l_open = 1;
        end
      end
      DOOR_OPEN: begin
        if (e_opened) begin
          p_dtk[1] = 0; e_opened = 0;
        end
        if (p_dtk[1] < 2 * TICKS_PER_SECOND) p_dtk[1]++;
        if (p_dtk[1] >= 2 * TICKS_PER_SECOND && f_close) begin
          p_door = DOOR_TRYING; e_opened = 1;
        end
      end
      DOOR_TRYING: begin
        l_open = 0;
        if (blocked) p_door = DOOR_ALARM;
        else begin
          p_door = DOOR_CLOSING; l_cl = 1;
        end
      end
      DOOR_ALARM: begin
        if (p_blink < TICKS_PER_SECOND / 2) p_blink++;
        if (p_blink >= TICKS_PER_SECOND / 2) begin
          l_al = ~l_al; p_blink = 0;
        end
        if (!blocked) begin
          p_door = DOOR_CLOSING; l_al = 0;
        end
      end
      DOOR_CLOSING: begin
        if (e_closing) begin
          p_dtk[2] = 0; e_closing = 0;
        end
        if (p_dtk[2] < thr) p_dtk[2]++;
        if (p_dtk[2] >= thr && f_close) begin
          p_door = DOOR_CLOSED; f_close = 0; e_closing = 1; l_cl = 0;
        end
      end
      default: ;
    endcase
  endfunction

  // one tick: enqueue, car, door, head compare and dequeue; returns the shown status
  function automatic status_t elevator_tick(tick_t t);
    int fl;
    status_t s;
    fl = int'(t.flr);
    if (t.rq && fl >= -int'(p_bas) && fl <= int'(p_top) && p_qn < QUEUE_DEPTH) begin
      p_queue[p_qn] = fl; p_qn++;
    end
    car_step();
    door_step(t.obs);
    if (p_qn > 0) begin
      if (p_pos == p_queue[0]) begin
        f_at = 1; f_up = 0; f_dn = 0; f_move = 0;
        for (int j = 1; j < p_qn; j++) p_queue[j-1] = p_queue[j];
        p_queue[p_qn-1] = 0;
        p_qn--;
      end else if (p_pos < p_queue[0]) begin
        f_up = 1; f_move = 1; f_dn = 0; f_at = 0;
      end else begin
        f_dn = 1; f_move = 1; f_up = 0; f_at = 0;
      end
    end
    if (p_car == CAR_RETURN) begin
      if (p_pos == 0) begin
        f_at = 1; f_up = 0; f_dn = 0; f_move = 0;
      end else begin
        if (f_up) begin
          l_st = 1; p_car = CAR_UP;
        end
        if (f_dn) begin
          l_st = 1; p_car = CAR_DOWN;
        end
      end
    end
    s.car = p_car; s.door = p_door; s.flr = p_pos[5:0]; s.dir = p_dir;
    s.mv = l_mv; s.st = l_st; s.op = l_op; s.opn = l_open; s.cl = l_cl; s.al = l_al;
    s.pend = p_qn[3:0];
    return s;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    $display("%0t: %s mismatch, got %0d expected %0d", $realtime, what, got, want);
  endtask

  // result side: checks and stalls
  always @(posedge clk) begin
    status_t got;
    status_t want;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        got = res_ch.data;
        if (expected_status.size() == 0) report_mismatch("unexpected result", 1, 0);
        else begin
          want = expected_status.pop_front();
          if (got.car != want.car) report_mismatch("car_mode_out", got.car, want.car);
          if (got.door != want.door) report_mismatch("door_mode_out", got.door, want.door);
          if (got.flr != want.flr) report_mismatch("current_floor", got.flr, want.flr);
          if (got.dir != want.dir) report_mismatch("direction_mark", got.dir, want.dir);
          if (got.mv != want.mv) report_mismatch("moving_lamp", got.mv, want.mv);
          if (got.st != want.st) report_mismatch("stopped_lamp", got.st, want.st);
          if (got.op != want.op) report_mismatch("opening_lamp", got.op, want.op);
          if (got.opn != want.opn) report_mismatch("open_lamp", got.opn, want.opn);
          if (got.cl != want.cl) report_mismatch("closing_lamp", got.cl, want.cl);
          if (got.al != want.al) report_mismatch("alarm_lamp", got.al, want.al);
          if (got.pend != want.pend) report_mismatch("pending_total", got.pend, want.pend);
        end
      end
      // long hold-off on request, else random stalls by mode
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        res_ch.ready <= 1'b0;
      end else if (hold_request) begin
        hold_request <= 1'b0;
        hold_left <= HOLD_CYCLES;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= (idle_mode == 0 ? 84 : idle_mode == 1 ? 8 : 0));
      end
    end
  end

  // offer one tick and wait for it to be taken
  task automatic send_tick(tick_t t, bit typed, status_t want);
    status_t pred;
    req_ch.valid <= 1'b1;
    req_ch.data <= t;
    do @(posedge clk); while (!req_ch.ready);
    pred = elevator_tick(t);
    expected_status.push_back(typed ? want : pred);
  endtask

  task automatic sender_gap();
    int pct;
    pct = (idle_mode == 0) ? 8 : (idle_mode == 1) ? 84 : 0;
    if ($urandom_range(99) < pct) begin
      req_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < pct);
    end
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic cfg_write(reg_index_t idx, int v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v[CFG_DATA_W-1:0];
    @(posedge clk);
    model_config(idx, v);
  endtask

  // directed ticks: range edges, noise, queue overflow, obstruction
  row_t plan_rows [18] = '{
    '{0, 0, 0, 1, DOORS_OPENING_AT_GROUND},
    '{1, 20, 0, 1, DOORS_OPENING_AT_GROUND},
    '{1, -5, 0, 1, DOORS_OPENING_AT_GROUND},
    '{1, 17, 0, 0, '0},
    '{1, -3, 0, 0, '0},
    '{1, 16, 0, 0, '0},
    '{1, 0, 1, 0, '0},
    '{0, 31, 1, 0, '0},
    '{0, -32, 0, 0, '0},
    '{1, -4, 1, 0, '0},
    '{1, 1, 0, 0, '0},
    '{1, 2, 0, 0, '0},
    '{1, 3, 1, 0, '0},
    '{1, 4, 0, 0, '0},
    '{1, 5, 0, 0, '0},
    '{1, 6, 1, 0, '0},
    '{1, 7, 0, 0, '0},
    '{1, 8, 0, 0, '0}
  };

  initial begin
    tick_t t;
    int blocked_left;
    int fl;
    rst = 1'b1;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    req_ch.valid = 1'b0; req_ch.data = '0;
    model_reset();
    blocked_left = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan_rows[i]) begin
      t.rq = plan_rows[i].rq; t.flr = plan_rows[i].flr[5:0]; t.obs = plan_rows[i].obs;
      send_tick(t, plan_rows[i].typed, plan_rows[i].want);
      sender_gap();
    end

    for (int ph = 0; ph < 3; ph++) begin
      wait_drained();
      idle_mode = ph;
      case (ph)
        0: begin
          // out of range values must be ignored
          cfg_write(REG_FLOOR_TRAVEL, 0);
          cfg_write(REG_DOOR_TRAVEL, 11);
          cfg_write(REG_TOP_FLOOR, 21);
          cfg_write(REG_BASEMENTS, 6);
          cfg_write(REG_BASEMENTS, 0);
          cfg_write(REG_DOOR_TRAVEL, 2);
        end
        1: begin
          cfg_write(REG_FLOOR_TRAVEL, 1);
          cfg_write(REG_DOOR_TRAVEL, 1);
          cfg_write(REG_TOP_FLOOR, 20);
          cfg_write(REG_BASEMENTS, 5);
        end
        default: begin
          cfg_write(REG_FLOOR_TRAVEL, 10);
          cfg_write(REG_DOOR_TRAVEL, 10);
          cfg_write(REG_TOP_FLOOR, 1);
          cfg_write(REG_BASEMENTS, 1);
        end
      endcase
      cfg_we <= 1'b0;
      @(posedge clk);

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 2 && n == 40) hold_request <= 1'b1;
        if (ph == 1 && n == 250) wait_drained();
        // obstruction comes in bursts so the alarm lamp gets to blink
        if (blocked_left > 0) blocked_left--;
        else if ($urandom_range(99) < 4) blocked_left = $urandom_range(15, 1);
        t.obs = (blocked_left > 0);
        t.rq = ($urandom_range(99) < 10);
        if ($urandom_range(99) < 85)
          fl = int'($urandom_range(p_top + p_bas)) - int'(p_bas);
        else
          fl = int'($urandom_range(63)) - 32;
        t.flr = fl[5:0];
        send_tick(t, 1'b0, '0);
        sender_gap();
      end
    end

    wait_drained();
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
